FILE: sv/hrr_pkg.sv
// hrr_pkg: shared types and constants of the hermite ratio resampler
// used by hrr_ctrl, hrr_datapath and hermite_ratio_resampler; no dependencies
package hrr_pkg;

   localparam int LEN_W      = 24;
   localparam int CSR_ADDR_W = 2;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_RATIO    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SOURCE_LENGTH = 2'd1;

   // what the accumulator takes in one cycle
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_A2,
      ACC_MUL_SUB_B2,
      ACC_MUL_ADD_C2,
      ACC_MUL_ADD_X0
   } acc_sel_type;

   typedef struct packed {
      logic        load;
      acc_sel_type acc_sel;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic pos_zero;
      logic slot_free;
   } status_type;

endpackage

FILE: sv/hrr_ctrl.sv
// hrr_ctrl: sequencer of the resampler, one item in flight at a time
// drives hrr_datapath through hrr_pkg::cmd_type, reads hrr_pkg::status_type
module hrr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  hrr_pkg::status_type status,
   output hrr_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.acc_sel = hrr_pkg::ACC_HOLD;
      cmd.emit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.active) begin
               state_in = ST_IDLE;
            end else if (status.pos_zero) begin
               // position zero gives a zero sample, no interpolation
               state_in = ST_EMIT;
            end else begin
               cmd.acc_sel = hrr_pkg::ACC_LOAD_A2;
               state_in    = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.acc_sel = hrr_pkg::ACC_MUL_SUB_B2;
            state_in    = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.acc_sel = hrr_pkg::ACC_MUL_ADD_C2;
            state_in    = ST_MUL_C;
         end
         ST_MUL_C: begin
            cmd.acc_sel = hrr_pkg::ACC_MUL_ADD_X0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/hrr_datapath.sv
// hrr_datapath: sample window, phase and position, shared horner multiplier,
// output register; commanded by hrr_ctrl, types from hrr_pkg
module hrr_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hrr_pkg::cmd_type              cmd,
   output hrr_pkg::status_type           status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_first,
   input  logic [PHASE_BITS+1:0]         ratio,
   input  logic [hrr_pkg::LEN_W-1:0]     length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_last,
   output logic                          rsp_finished
);

   localparam int LW = hrr_pkg::LEN_W;
   localparam int AW = SAMPLE_BITS + 8;

   logic signed [SAMPLE_BITS-1:0] win_ff [4];
   logic [PHASE_BITS-1:0] phase_ff;
   logic [LW-1:0]         pos_ff;
   logic [LW-1:0]         rcv_ff;
   logic                  done_ff;
   logic signed [AW-1:0]  acc_ff, acc_in;

   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_last_ff;
   logic                          out_fin_ff;

   // coefficients, all exact
   logic signed [AW-1:0] xm1, x0, x1, x2, c2, v2, w2, a2, b2, two_x0;
   logic signed [AW+PHASE_BITS:0] prod;
   logic signed [AW+PHASE_BITS:0] prod_sh;
   logic signed [AW-1:0] mul_term;
   logic signed [AW-1:0] rnd;
   logic [AW-SAMPLE_BITS:0] rnd_top;
   logic signed [SAMPLE_BITS-1:0] sat;

   logic [PHASE_BITS+2:0] phase_sum;
   logic [LW-1:0]         pos_next;
   logic                  done_next;
   logic                  more_next;
   logic                  active;

   assign xm1    = AW'(win_ff[0]);
   assign x0     = AW'(win_ff[1]);
   assign x1     = AW'(win_ff[2]);
   assign x2     = AW'(win_ff[3]);
   assign c2     = x1 - xm1;
   assign v2     = (x0 - x1) <<< 1;
   assign w2     = c2 + v2;
   assign a2     = w2 + v2 + (x2 - x0);
   assign b2     = w2 + a2;
   assign two_x0 = x0 <<< 1;

   // floor(acc * phase / 2^PHASE_BITS)
   assign prod     = acc_ff * signed'({1'b0, phase_ff});
   assign prod_sh  = prod >>> PHASE_BITS;
   assign mul_term = prod_sh[AW-1:0];

   always_comb begin
      unique case (cmd.acc_sel)
         hrr_pkg::ACC_LOAD_A2:    acc_in = a2;
         hrr_pkg::ACC_MUL_SUB_B2: acc_in = mul_term - b2;
         hrr_pkg::ACC_MUL_ADD_C2: acc_in = mul_term + c2;
         hrr_pkg::ACC_MUL_ADD_X0: acc_in = mul_term + two_x0;
         default:                 acc_in = acc_ff;
      endcase
   end

   // round half up, then clamp to the sample range
   assign rnd     = (acc_ff + AW'(1)) >>> 1;
   assign rnd_top = rnd[AW-1:SAMPLE_BITS-1];
   always_comb begin
      if (rnd_top == '0 || rnd_top == '1) begin
         sat = rnd[SAMPLE_BITS-1:0];
      end else if (rnd[AW-1]) begin
         sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   assign phase_sum = (PHASE_BITS+3)'(phase_ff) + (PHASE_BITS+3)'(ratio);
   assign pos_next  = pos_ff + LW'(phase_sum[PHASE_BITS+2:PHASE_BITS]);
   assign done_next = (({1'b0, pos_next} + (LW+1)'(8)) >= {1'b0, length});
   assign more_next = !done_next && ({1'b0, rcv_ff} == {1'b0, pos_next} + (LW+1)'(3));

   assign active = !done_ff && ({1'b0, rcv_ff} == {1'b0, pos_ff} + (LW+1)'(3));

   assign status.active    = active;
   assign status.pos_zero  = (pos_ff == '0);
   assign status.slot_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            win_ff[i] <= '0;
         end
         phase_ff <= '0;
         pos_ff   <= '0;
         rcv_ff   <= '0;
         done_ff  <= 1'b0;
      end else if (cmd.load) begin
         if (req_first) begin
            win_ff[0] <= '0;
            win_ff[1] <= '0;
            win_ff[2] <= '0;
            phase_ff  <= '0;
            pos_ff    <= '0;
            rcv_ff    <= LW'(1);
            done_ff   <= 1'b0;
         end else begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= win_ff[3];
            if (rcv_ff != hrr_pkg::LEN_MAX) begin
               rcv_ff <= rcv_ff + LW'(1);
            end
         end
         win_ff[3] <= req_sample;
      end else if (cmd.emit) begin
         phase_ff <= phase_sum[PHASE_BITS-1:0];
         pos_ff   <= pos_next;
         done_ff  <= done_next;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.emit) begin
         out_sample_ff <= (pos_ff == '0) ? '0 : sat;
         out_last_ff   <= !more_next;
         out_fin_ff    <= done_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_sample   = out_sample_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_finished = out_fin_ff;

   a_emit_when_active: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> active && status.slot_free)
      else $error("item emitted outside the output loop or onto a full slot");

   a_load_when_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !active)
      else $error("new item taken while outputs were still due");

   a_last_ends_loop: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !more_next |=> !active)
      else $error("loop continues after an item marked last");

endmodule

FILE: sv/hermite_ratio_resampler.sv
// Fractional-ratio resampler with a 4-point cubic Hermite interpolator. Source
// samples come in on req_, interpolated samples go out on rsp_; each input item
// yields zero or more result items, the last of them marked by rsp_tlast.
// One item is worked on at a time: an input is accepted in ST_IDLE, ST_CHECK
// decides whether an output is due, and each interpolated output then passes
// ST_MUL_A, ST_MUL_B, ST_MUL_C and ST_EMIT (3 horner steps through one shared
// multiplier, then round and hand-off, stalled until the output slot is free);
// a zero-position output skips to ST_EMIT. A finished result waits in an
// output register while the next input is accepted.
module hermite_ratio_resampler #(
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   // tdata: sample_in
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: first_of_table
   input  logic                             req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: sample_out
   output logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   // tuser: finished
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [hrr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [((PHASE_BITS+2 > hrr_pkg::LEN_W) ? PHASE_BITS+2 : hrr_pkg::LEN_W)-1:0]
                                            csr_wdata
);

   localparam int RW = PHASE_BITS + 2;
   localparam int LW = hrr_pkg::LEN_W;
   localparam logic [RW-1:0] RATIO_ONE = RW'(1) << PHASE_BITS;
   localparam logic [RW-1:0] RATIO_MIN = RW'(1) << (PHASE_BITS - 6);

   logic [RW-1:0] ratio_ff;
   logic [LW-1:0] length_ff;
   logic [RW-1:0] ratio_eff;

   hrr_pkg::cmd_type    cmd;
   hrr_pkg::status_type status;

   logic signed [SAMPLE_BITS-1:0] out_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff  <= RATIO_ONE;
         length_ff <= hrr_pkg::LEN_MAX;
      end else if (csr_we) begin
         unique case (csr_addr)
            hrr_pkg::REG_STEP_RATIO:    ratio_ff  <= csr_wdata[RW-1:0];
            hrr_pkg::REG_SOURCE_LENGTH: length_ff <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // ratios below 1/64 run as 1/64
   assign ratio_eff = (ratio_ff < RATIO_MIN) ? RATIO_MIN : ratio_ff;

   hrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   hrr_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PHASE_BITS  (PHASE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_tdata[SAMPLE_BITS-1:0]),
      .req_first    (req_tuser),
      .ratio        (ratio_eff),
      .length       (length_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_sample   (out_sample),
      .rsp_last     (rsp_tlast),
      .rsp_finished (rsp_tuser)
   );

   always_comb begin
      rsp_tdata                = '0;
      rsp_tdata[SAMPLE_BITS-1:0] = out_sample;
   end

endmodule
